FILE: src/csp_pkg.sv
// Shared types and constants for the cross stencil smoothing pass unit.
// Used by the top level and by its port list; no other dependencies.
`timescale 1ns / 1ps

package csp_pkg;

    // Configuration port geometry and register indexes.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 11'd1024;
    localparam int unsigned           DIM_MIN   = 3;

    // Item kinds on the input channel.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // 1.0 in unsigned Q1.15.
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef struct packed {
        logic        op;
        logic [15:0] pixel_value;
    } csp_in_t;

    typedef struct packed {
        logic [15:0] smoothed_value;
        logic        end_of_frame;
    } csp_out_t;

endpackage

FILE: src/csp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module csp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/cross_stencil_smoothing_pass_unit.sv
// Top level of the cross stencil smoothing pass unit.
// Depends on csp_pkg and on csp_ram for the two line stores.
`timescale 1ns / 1ps

// One five-point smoothing pass over a raster-order image of unsigned Q1.15
// pixels. The unit takes one item per clock cycle when the result side keeps
// m_ready high; each item goes through a read stage, which issues its
// line-store reads, and a compute stage, which fills the output register.
// The throughput is set by the single read port of each of the line stores:
// every item reads one entry of each store and the line-store reads and
// writes of consecutive items never touch the same entry. Results lag the
// input by one row: the first row gives no results, and after the last row
// the caller sends width_in_use drain items (op = 1) that flush it, the last
// of them flagged with end_of_frame. Pixel items after a full frame and drain
// items at any other time are dropped without a result. Writing either
// dimension register restarts the frame; it must only be done while no
// transfer is outstanding. Line-store contents are not cleared by reset.
module cross_stencil_smoothing_pass_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  csp_pkg::csp_in_t                    s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output csp_pkg::csp_out_t                   m_data,

    input  logic                                cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    import csp_pkg::*;

    // Column index width and row counter width (the row counter reaches the
    // height itself during the drain phase).
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

    localparam int unsigned W_RST = (MAX_WIDTH  < 1024) ? MAX_WIDTH  : 1024;
    localparam int unsigned H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // Frame geometry, kept in the form the control logic compares against.
    logic [AW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_eff_reg,  h_eff_next;

    // Position of the next item.
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Compute stage: item whose line-store reads are in flight.
    logic          b_valid_reg, b_valid_next;
    logic          b_drain_reg;
    logic          b_edge_reg;
    logic          b_last_reg;
    logic          b_emit_reg;
    logic          b_pass_reg;
    logic [AW-1:0] b_col_reg;
    logic [15:0]   b_pix_reg;

    // Horizontal window over the row above: the center and left pixels are
    // the two previous "right" reads. Column zero lives in its own register,
    // since item zero has no earlier read to inherit it from.
    logic [15:0]   ctr_reg;
    logic [15:0]   lft_reg;
    logic [15:0]   col0_reg;

    // Output register.
    logic          m_valid_reg, m_valid_next;
    csp_out_t      m_data_reg;

    // Line-store ports.
    logic          above_we;
    logic          rd_en;
    logic [AW-1:0] above_raddr;
    logic [15:0]   above_rdata;
    logic          two_we;
    logic [15:0]   two_rdata;

    // Handshake and classification.
    logic          accept;
    logic          b_advance;
    logic          is_drain;
    logic          frame_full;
    logic          launch;
    logic          col_is_last;

    // Datapath.
    logic [15:0]   center;
    logic [18:0]   stencil_sum;
    logic [15:0]   result_value;

    logic [31:0]   cfg_clamped;

    // The compute stage moves on when the output register is free or is
    // being emptied in the same cycle; the input side follows it.
    assign b_advance  = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !b_valid_reg || b_advance;
    assign accept     = s_valid && s_ready;

    assign is_drain    = (s_data.op == OP_DRAIN);
    assign frame_full  = (row_reg == h_eff_reg);
    assign col_is_last = (col_reg == w_last_reg);
    // Drain items only count after a full frame, pixel items only before.
    assign launch      = accept && (is_drain == frame_full);

    // Each item reads the right-hand neighbor from the row above and the
    // pixel straight up from the row two above. The row above is written
    // with the new pixel at once; its old value was captured as "right" by
    // the previous item.
    assign rd_en       = launch;
    assign above_raddr = col_reg + AW'(1);
    assign above_we    = launch && !is_drain;
    assign two_we      = b_advance && !b_drain_reg;

    csp_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .aclk  (aclk),
        .we    (above_we),
        .waddr (col_reg),
        .wdata (s_data.pixel_value),
        .re    (rd_en),
        .raddr (above_raddr),
        .rdata (above_rdata)
    );

    csp_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .aclk  (aclk),
        .we    (two_we),
        .waddr (b_col_reg),
        .wdata (center),
        .re    (rd_en),
        .raddr (col_reg),
        .rdata (two_rdata)
    );

    // Stencil on the row above: 4*center + up + down + left + right,
    // rounded half up and divided by eight.
    assign center      = (b_col_reg == '0) ? col0_reg : ctr_reg;
    assign stencil_sum = {1'b0, center, 2'b00} + 19'(two_rdata) + 19'(b_pix_reg)
                       + 19'(lft_reg) + 19'(above_rdata) + 19'd4;

    always_comb begin
        priority if (b_edge_reg) begin
            result_value = ONE_Q15;
        end else if (b_pass_reg) begin
            result_value = center;
        end else begin
            result_value = stencil_sum[18:3];
        end
    end

    always_comb begin
        cfg_clamped  = 32'(cfg_wdata);
        w_last_next  = w_last_reg;
        h_eff_next   = h_eff_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        b_valid_next = b_valid_reg;
        m_valid_next = m_valid_reg;

        if (cfg_we) begin
            if (cfg_index == REG_WIDTH_IN_USE) begin
                if (cfg_clamped < DIM_MIN) begin
                    cfg_clamped = DIM_MIN;
                end else if (cfg_clamped > MAX_WIDTH) begin
                    cfg_clamped = MAX_WIDTH;
                end
                w_last_next = AW'(cfg_clamped - 32'd1);
                col_next    = '0;
                row_next    = '0;
            end else if (cfg_index == REG_HEIGHT_IN_USE) begin
                if (cfg_clamped < DIM_MIN) begin
                    cfg_clamped = DIM_MIN;
                end else if (cfg_clamped > MAX_HEIGHT) begin
                    cfg_clamped = MAX_HEIGHT;
                end
                h_eff_next = RW'(cfg_clamped);
                col_next   = '0;
                row_next   = '0;
            end
        end else if (launch) begin
            if (col_is_last) begin
                col_next = '0;
                // The last drain item ends the frame; the last pixel of a
                // row moves on to the next row.
                row_next = is_drain ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end

        if (launch) begin
            b_valid_next = 1'b1;
        end else if (b_advance) begin
            b_valid_next = 1'b0;
        end

        if (b_advance && b_emit_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg  <= AW'(W_RST - 1);
            h_eff_reg   <= RW'(H_RST);
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            w_last_reg  <= w_last_next;
            h_eff_reg   <= h_eff_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (launch) begin
            b_drain_reg <= is_drain;
            b_edge_reg  <= (col_reg == '0) || col_is_last;
            b_last_reg  <= col_is_last;
            // Drain items always give a result; pixel items from the second
            // row on. Drain items and the second row pass the row above.
            b_emit_reg  <= is_drain || (row_reg != '0);
            b_pass_reg  <= is_drain || (row_reg == RW'(1));
            b_col_reg   <= col_reg;
            b_pix_reg   <= s_data.pixel_value;
        end
        if (b_advance) begin
            lft_reg <= center;
            ctr_reg <= above_rdata;
            if (!b_drain_reg && (b_col_reg == '0)) begin
                col0_reg <= b_pix_reg;
            end
        end
        if (b_advance && b_emit_reg) begin
            m_data_reg.smoothed_value <= result_value;
            m_data_reg.end_of_frame   <= b_drain_reg && b_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
